// ----- sv/u8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: decoder state and result types,
// byte range limits and the count cap. No dependencies.
package u8sd_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned CountWidth = 17;

  // Buffer size bound; the count saturates at the smaller of this and the count range.
  localparam int unsigned MaxBufferBytes = 65536;
  localparam int unsigned CountRangeMax  = (1 << CountWidth) - 1;
  localparam logic [CountWidth-1:0] CountCap =
    CountWidth'((MaxBufferBytes > CountRangeMax) ? CountRangeMax : MaxBufferBytes);

  // Byte limits
  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] ContMax    = 8'hBF;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] E0SecondLo = 8'hA0;
  localparam logic [7:0] EDSecondHi = 8'h9F;
  localparam logic [7:0] F0SecondLo = 8'h90;
  localparam logic [7:0] F4SecondHi = 8'h8F;

  typedef struct packed {
    logic [CpWidth-1:0]    partial;
    logic [1:0]            need;
    logic                  second;
    logic [7:0]            lead;
    logic [CountWidth-1:0] count;
  } dec_state_t;

  typedef struct packed {
    logic                  emit;
    logic [CpWidth-1:0]    code_point;
    logic                  has_code_point;
    logic                  end_of_buffer;
    logic [CountWidth-1:0] unit_count;
  } dec_result_t;

endpackage

// ----- sv/u8sd_step.sv -----
// One decode step: next decoder state and result for one byte.
// Pure combinational logic; uses u8sd_pkg.
module u8sd_step
  import u8sd_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  logic [7:0]         lo;
  logic [7:0]         hi;
  logic               cont_ok;
  logic               as_lead;
  logic               have;
  logic [CpWidth-1:0] cp;
  logic [CpWidth-1:0] shifted;

  // Second byte limits depend on the lead
  always_comb begin
    lo = ContMin;
    hi = ContMax;
    if (state_i.second) begin
      case (state_i.lead)
        LeadE0:  lo = E0SecondLo;
        LeadED:  hi = EDSecondHi;
        LeadF0:  lo = F0SecondLo;
        LeadF4:  hi = F4SecondHi;
        default: ;
      endcase
    end
    cont_ok = (data_byte_i >= lo) && (data_byte_i <= hi);
  end

  assign shifted = {state_i.partial[CpWidth-7:0], data_byte_i[5:0]};

  always_comb begin
    state_o = state_i;
    have    = 1'b0;
    cp      = '0;
    as_lead = 1'b0;

    if (state_i.need != 2'd0) begin
      if (cont_ok) begin
        state_o.partial = shifted;
        state_o.need    = state_i.need - 2'd1;
        state_o.second  = 1'b0;
        if (state_i.need == 2'd1) begin
          cp              = shifted;
          have            = 1'b1;
          state_o.partial = '0;
          state_o.lead    = '0;
        end
      end else begin
        // drop the open sequence, decode this byte again as a lead
        as_lead = 1'b1;
      end
    end else begin
      as_lead = 1'b1;
    end

    if (as_lead) begin
      state_o.partial = '0;
      state_o.need    = 2'd0;
      state_o.second  = 1'b0;
      state_o.lead    = '0;
      if (data_byte_i <= AsciiMax) begin
        cp   = CpWidth'(data_byte_i);
        have = 1'b1;
      end else if (data_byte_i inside {[Lead2Min:Lead2Max]}) begin
        state_o.partial = CpWidth'(data_byte_i[4:0]);
        state_o.need    = 2'd1;
        state_o.second  = 1'b1;
        state_o.lead    = data_byte_i;
      end else if (data_byte_i inside {[Lead3Min:Lead3Max]}) begin
        state_o.partial = CpWidth'(data_byte_i[3:0]);
        state_o.need    = 2'd2;
        state_o.second  = 1'b1;
        state_o.lead    = data_byte_i;
      end else if (data_byte_i inside {[Lead4Min:Lead4Max]}) begin
        state_o.partial = CpWidth'(data_byte_i[2:0]);
        state_o.need    = 2'd3;
        state_o.second  = 1'b1;
        state_o.lead    = data_byte_i;
      end
    end

    if (have && (state_i.count < CountCap)) begin
      state_o.count = state_i.count + CountWidth'(1);
    end

    result_o.emit           = have | last_i;
    result_o.code_point     = cp;
    result_o.has_code_point = have;
    result_o.end_of_buffer  = last_i;
    result_o.unit_count     = state_o.count;

    // end of buffer: start the next one from scratch
    if (last_i) begin
      state_o = '0;
    end
  end

endmodule

// ----- sv/utf8_stream_decoder_core.sv -----
// Strict UTF-8 stream decoder: one byte in per cycle, at most one result per byte.
// Bytes enter an input register and pass through one decode step (u8sd_step)
// into a result register, which takes the result once it is free or draining;
// the block sustains one byte per cycle as long as results are taken.
// Code points come out as full 21-bit values; the buffer's last byte
// always yields a result carrying the count of code points in that buffer.
// Bytes that do not complete a code point and are not last yield nothing.
// Uses u8sd_pkg and u8sd_step.
module utf8_stream_decoder_core
  import u8sd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_buffer_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CpWidth-1:0]    code_point_o,
  output logic                  has_code_point_o,
  output logic                  end_of_buffer_res_o,
  output logic [CountWidth-1:0] unit_count_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        adv;

  dec_state_t  state_q, state_d;
  dec_result_t res;
  logic        out_vld_q, out_vld_d;
  dec_result_t out_q;

  u8sd_step u_step (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .last_i      (last_q),
    .state_o     (state_d),
    .result_o    (res)
  );

  // advance the held word when the result register is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (adv && res.emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= end_of_buffer_i;
    end
    if (adv && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign code_point_o        = out_q.code_point;
  assign has_code_point_o    = out_q.has_code_point;
  assign end_of_buffer_res_o = out_q.end_of_buffer;
  assign unit_count_o        = out_q.unit_count;

endmodule

// ----- sv/u8sd_checker.sv -----
// Port-level checks for utf8_stream_decoder_core, bound to the top level.
// Uses u8sd_pkg.
module u8sd_checker
  import u8sd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [CpWidth-1:0]    code_point_o,
  input logic                  has_code_point_o,
  input logic                  end_of_buffer_res_o,
  input logic [CountWidth-1:0] unit_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o)
      && $stable(unit_count_o) && $stable(has_code_point_o))
    else $error("stalled result changed");

  // every result carries a character or closes a buffer
  a_out_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_code_point_o || end_of_buffer_res_o)
    else $error("result without character or end of buffer");

  // empty results carry a zero code point
  a_no_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_code_point_o |-> code_point_o == '0)
    else $error("code point set without character");

  // decoded values are scalar values, never surrogates, and carry a nonzero count
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_code_point_o |-> code_point_o <= 21'h10FFFF
      && !(code_point_o >= 21'h00D800 && code_point_o <= 21'h00DFFF)
      && unit_count_o != '0)
    else $error("bad code point or zero count");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_u8sd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .code_point_o        (code_point_o),
  .has_code_point_o    (has_code_point_o),
  .end_of_buffer_res_o (end_of_buffer_res_o),
  .unit_count_o        (unit_count_o)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_core: streams UTF-8 buffers through the
// byte channel and checks every result word against a local strict-decoder prediction.
// Depends on u8sd_pkg and the decoder RTL only.
module tb_top;
  import u8sd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;  // wait for all results before sending this byte
  } stream_byte_t;

  typedef struct {
    logic [CpWidth-1:0]    cp;
    logic                  has_cp;
    logic                  eob;
    logic [CountWidth-1:0] count;
  } decoded_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic [7:0]            data_byte = 8'h00;
  logic                  end_flag = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [CpWidth-1:0]    code_point;
  logic                  has_cp;
  logic                  eob_res;
  logic [CountWidth-1:0] unit_count;

  always #10 clk_i = ~clk_i;

  utf8_stream_decoder_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .data_byte_i        (data_byte),
    .end_of_buffer_i    (end_flag),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .code_point_o       (code_point),
    .has_code_point_o   (has_cp),
    .end_of_buffer_res_o(eob_res),
    .unit_count_o       (unit_count)
  );

  stream_byte_t  byte_feed_q[$];
  decoded_word_t expected_words_q[$];
  logic [7:0]    staged_bytes[$];

  // decoder state as the prediction sees it
  logic [CpWidth-1:0]    seq_value = '0;
  logic [1:0]            seq_need = '0;
  logic                  seq_second = 1'b0;
  logic [7:0]            seq_lead = '0;
  logic [CountWidth-1:0] buf_count = '0;

  int  err_count = 0;
  int  results_pending = 0;
  bit  feed_done = 1'b0;
  bit  tail_quiet = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  buffers_built = 0;
  int  words_checked = 0;
  int  cps_checked = 0;

  task automatic report_mismatch(string what);
    err_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void drop_sequence();
    seq_value = '0;
    seq_need = '0;
    seq_second = 1'b0;
    seq_lead = '0;
  endfunction

  // Advance the predicted decoder by one byte; return 1 if the byte yields a word.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output decoded_word_t w);
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic               got;
    logic [CpWidth-1:0] cp;
    lo = ContMin;
    hi = ContMax;
    got = 1'b0;
    cp = '0;
    if (seq_second) begin
      case (seq_lead)
        LeadE0: lo = E0SecondLo;
        LeadED: hi = EDSecondHi;
        LeadF0: lo = F0SecondLo;
        LeadF4: hi = F4SecondHi;
        default: ;
      endcase
    end
    if (seq_need != 2'd0 && b >= lo && b <= hi) begin
      seq_value = {seq_value[CpWidth-7:0], b[5:0]};
      seq_need = seq_need - 2'd1;
      seq_second = 1'b0;
      if (seq_need == 2'd0) begin
        got = 1'b1;
        cp = seq_value;
        drop_sequence();
      end
    end else begin
      // drop any open sequence and take the byte as a lead
      drop_sequence();
      if (b <= AsciiMax) begin
        got = 1'b1;
        cp = CpWidth'(b);
      end else if (b >= Lead2Min && b <= Lead2Max) begin
        seq_value = CpWidth'(b[4:0]);
        seq_need = 2'd1;
      end else if (b >= Lead3Min && b <= Lead3Max) begin
        seq_value = CpWidth'(b[3:0]);
        seq_need = 2'd2;
      end else if (b >= Lead4Min && b <= Lead4Max) begin
        seq_value = CpWidth'(b[2:0]);
        seq_need = 2'd3;
      end
      if (seq_need != 2'd0) begin
        seq_second = 1'b1;
        seq_lead = b;
      end
    end
    if (got && buf_count < CountCap) buf_count++;
    w.cp = cp;
    w.has_cp = got;
    w.eob = last;
    w.count = buf_count;
    if (last) begin
      drop_sequence();
      buf_count = '0;
    end
    return got || last;
  endfunction

  function automatic void append_scalar(int unsigned cp);
    if (cp < 'h80) begin
      staged_bytes.push_back(8'(cp));
    end else if (cp < 'h800) begin
      staged_bytes.push_back(8'hC0 | 8'(cp >> 6));
      staged_bytes.push_back(8'h80 | 8'(cp & 'h3F));
    end else if (cp < 'h10000) begin
      staged_bytes.push_back(8'hE0 | 8'(cp >> 12));
      staged_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
      staged_bytes.push_back(8'h80 | 8'(cp & 'h3F));
    end else begin
      staged_bytes.push_back(8'hF0 | 8'(cp >> 18));
      staged_bytes.push_back(8'h80 | 8'((cp >> 12) & 'h3F));
      staged_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3F));
      staged_bytes.push_back(8'h80 | 8'(cp & 'h3F));
    end
  endfunction

  function automatic int unsigned random_scalar();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 'h7F);
      1: return $urandom_range('h80, 'h7FF);
      2: return $urandom_range('h800, 'hD7FF);
      3: return $urandom_range('hE000, 'hFFFF);
      default: return $urandom_range('h10000, 'h10FFFF);
    endcase
  endfunction

  // Move the staged bytes into the feed as one buffer, flagging its last byte.
  function automatic void flush_buffer(bit hold_first);
    stream_byte_t item;
    foreach (staged_bytes[i]) begin
      item.data = staged_bytes[i];
      item.last = (i == staged_bytes.size() - 1);
      item.hold = hold_first && (i == 0);
      byte_feed_q.push_back(item);
    end
    staged_bytes.delete();
    buffers_built++;
  endfunction

  // Byte channel driver
  always @(posedge clk_i) begin : byte_driver
    stream_byte_t nxt;
    bit           fire;
    bit           go;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      feed_done <= 1'b0;
      tail_quiet <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      go = in_valid && !fire;
      if (!go) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_feed_q.size() != 0 &&
                     !(byte_feed_q[0].hold && (fire || results_pending != 0))) begin
          nxt = byte_feed_q.pop_front();
          data_byte <= nxt.data;
          end_flag <= nxt.last;
          go = 1'b1;
          if (byte_feed_q.size() >= 60 && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 4);
        end
      end
      in_valid <= go;
      tail_quiet <= (byte_feed_q.size() < 60);
      feed_done <= (byte_feed_q.size() == 0) && !go;
    end
  end

  // Result monitor: predicts on accepted bytes, then checks accepted words
  always @(posedge clk_i) begin : word_monitor
    decoded_word_t w;
    decoded_word_t exp_w;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_byte(data_byte, end_flag, w)) expected_words_q.push_back(w);
      end
      if (out_valid && out_ready) begin
        words_checked++;
        if (has_cp) cps_checked++;
        if (expected_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word cp=%h has=%b eob=%b count=%0d",
                                    code_point, has_cp, eob_res, unit_count));
        end else begin
          exp_w = expected_words_q.pop_front();
          if (code_point !== exp_w.cp)
            report_mismatch($sformatf("code_point %h, expected %h", code_point, exp_w.cp));
          if (has_cp !== exp_w.has_cp)
            report_mismatch($sformatf("has_code_point %b, expected %b", has_cp, exp_w.has_cp));
          if (eob_res !== exp_w.eob)
            report_mismatch($sformatf("end_of_buffer_res %b, expected %b", eob_res, exp_w.eob));
          if (unit_count !== exp_w.count)
            report_mismatch($sformatf("unit_count %0d, expected %0d", unit_count, exp_w.count));
        end
      end
      results_pending <= expected_words_q.size();
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!tail_quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 4);
      end
    end
  end

  initial begin : run_ctrl
    logic [7:0]  good_buf [13] = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hED, 8'h9F,
                                   8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    logic [7:0]  bad_buf [16] = '{8'hE0, 8'h9F, 8'hF0, 8'h8F, 8'hF4, 8'h90, 8'hED, 8'hA0,
                                  8'hF5, 8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90, 8'h80, 8'hE1};
    logic [7:0]  leads [4] = '{LeadE0, LeadED, LeadF0, LeadF4};
    int          random_bytes;
    int          n;
    int          base;
    bit          broken_buf;
    bit          first_rand;
    int unsigned cp;

    // directed: range extremes, then second-byte and lead rejections ending in a cut-off sequence
    foreach (good_buf[i]) staged_bytes.push_back(good_buf[i]);
    flush_buffer(1'b0);
    foreach (bad_buf[i]) staged_bytes.push_back(bad_buf[i]);
    flush_buffer(1'b0);
    // lone invalid byte as a whole buffer
    staged_bytes.push_back(8'hFF);
    flush_buffer(1'b0);

    random_bytes = 0;
    first_rand = 1'b1;
    while (random_bytes < 520) begin
      n = $urandom_range(1, 12);
      broken_buf = ($urandom_range(0, 4) == 0);
      repeat (n) begin
        if (broken_buf ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 9) == 0)) begin
          case ($urandom_range(0, 3))
            0: staged_bytes.push_back(8'($urandom_range(0, 255)));
            1: begin
              // cut a multi-byte sequence short
              base = staged_bytes.size();
              cp = $urandom_range('h80, 'h10FFFF);
              append_scalar(cp);
              repeat ($urandom_range(1, staged_bytes.size() - base - 1))
                void'(staged_bytes.pop_back());
            end
            2: begin
              // probe the narrowed second-byte ranges
              if ($urandom_range(0, 1) == 0) staged_bytes.push_back(leads[$urandom_range(0, 3)]);
              else staged_bytes.push_back(8'($urandom_range(Lead2Min, Lead4Max)));
              staged_bytes.push_back(8'($urandom_range(ContMin, ContMax)));
            end
            default: begin
              if ($urandom_range(0, 1) == 0)
                staged_bytes.push_back(8'($urandom_range(ContMin, 'hC1)));
              else
                staged_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
            end
          endcase
        end else begin
          append_scalar(random_scalar());
        end
      end
      random_bytes += staged_bytes.size();
      flush_buffer(first_rand);
      first_rand = 1'b0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (!(feed_done && results_pending == 0));
    repeat (20) @(posedge clk_i);

    $display("Streamed %0d buffers of valid, broken and cut-off UTF-8 under random stalls.",
             buffers_built);
    $display("%0d words checked, %0d code points; mismatches: %0d",
             words_checked, cps_checked, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Timeout: results still outstanding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
